@@ rtl/archive_hash_and_table_decrypt_top_defines.svh @@
// assertion macros for the archive hash and decrypt block
`ifndef ARCHIVE_HASH_AND_TABLE_DECRYPT_TOP_DEFINES_SVH
`define ARCHIVE_HASH_AND_TABLE_DECRYPT_TOP_DEFINES_SVH

// antecedent in this cycle implies consequent in the next
`define AHTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// property that holds at every edge out of reset
`define AHTD_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

`endif

@@ rtl/ahtd_pkg.sv @@
package ahtd_pkg;

    localparam int unsigned TABLE_WORDS = 1280;
    localparam int unsigned ADDR_W      = $clog2(TABLE_WORDS);

    localparam logic [31:0] GEN_SEED = 32'h0010_0001;
    localparam logic [31:0] GEN_MULT = 32'd125;
    localparam logic [31:0] GEN_INC  = 32'd3;
    localparam logic [31:0] GEN_MOD  = 32'h002A_AAAB;

    localparam logic [31:0] HASH_SEED1 = 32'h7FED_7FED;
    localparam logic [31:0] HASH_SEED2 = 32'hEEEE_EEEE;
    localparam logic [31:0] KEY_ADD    = 32'h1111_1111;
    localparam logic [31:0] MIX_INC    = 32'd3;

    localparam logic [ADDR_W-1:0] KEY_REGION = ADDR_W'(11'h400);

    localparam logic [2:0] KIND_MAX = 3'd4;

    localparam logic OP_HASH    = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    typedef logic [31:0] crypt_table_t [0:TABLE_WORDS-1];

    typedef struct packed {
        logic        op;
        logic        first;
        logic [7:0]  ch;
        logic [31:0] data;
    } ahtd_item_t;

    function automatic crypt_table_t build_crypt_table();
        crypt_table_t t;
        logic [31:0]  s;
        logic [15:0]  hi;
        s  = GEN_SEED;
        hi = '0;
        for (int col = 0; col < 256; col++) begin
            for (int row = 0; row < 5; row++) begin
                s  = (s * GEN_MULT + GEN_INC) % GEN_MOD;
                hi = s[15:0];
                s  = (s * GEN_MULT + GEN_INC) % GEN_MOD;
                t[row * 256 + col] = {hi, s[15:0]};
            end
        end
        return t;
    endfunction

    localparam crypt_table_t CRYPT_TABLE = build_crypt_table();

endpackage

@@ rtl/ahtd_in_stage.sv @@
module ahtd_in_stage (
    input  logic               aclk,
    input  logic               load,
    input  logic               op,
    input  logic               first,
    input  logic [31:0]        data_in,
    input  logic [2:0]         hash_kind,
    output ahtd_pkg::ahtd_item_t item,
    output logic [31:0]        rom_word
);
    import ahtd_pkg::*;

    ahtd_item_t        item_reg;
    ahtd_item_t        item_next;
    logic [31:0]       rom_word_reg;
    logic [7:0]        ch_up;
    logic [2:0]        kind_sat;
    logic [ADDR_W-1:0] rom_addr;

    always_comb begin
        ch_up = data_in[7:0];
        if (data_in[7:0] >= CHAR_LOW_A && data_in[7:0] <= CHAR_LOW_Z) begin
            ch_up = data_in[7:0] - CASE_DIFF;
        end
        kind_sat = (hash_kind > KIND_MAX) ? KIND_MAX : hash_kind;
        rom_addr = {kind_sat, ch_up};
        item_next.op    = op;
        item_next.first = first;
        item_next.ch    = ch_up;
        item_next.data  = data_in;
    end

    // crypt table rom, registered read
    always_ff @(posedge aclk) begin
        if (load) begin
            rom_word_reg <= CRYPT_TABLE[rom_addr];
            item_reg     <= item_next;
        end
    end

    assign item     = item_reg;
    assign rom_word = rom_word_reg;

endmodule

@@ rtl/ahtd_core.sv @@
module ahtd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  ahtd_pkg::ahtd_item_t item,
    input  logic [31:0]          rom_word,
    output logic [31:0]          value_out
);
    import ahtd_pkg::*;

    logic [31:0] hash_acc_reg, hash_acc_next;
    logic [31:0] hash_mix_reg, hash_mix_next;
    logic [31:0] dec_key_reg,  dec_key_next;
    logic [31:0] dec_mix_reg,  dec_mix_next;
    logic [31:0] value_reg,    value_next;

    logic [31:0] acc_base, mix_base, key_base, dmix_base;
    logic [31:0] hash_new, dmix_sum, plain;

    always_comb begin
        acc_base  = item.first ? HASH_SEED1 : hash_acc_reg;
        mix_base  = item.first ? HASH_SEED2 : hash_mix_reg;
        key_base  = item.first ? hash_acc_reg : dec_key_reg;
        dmix_base = item.first ? HASH_SEED2 : dec_mix_reg;

        hash_new = rom_word ^ (acc_base + mix_base);
        dmix_sum = dmix_base + CRYPT_TABLE[KEY_REGION + {3'b000, key_base[7:0]}];
        plain    = item.data ^ (key_base + dmix_sum);

        hash_acc_next = hash_acc_reg;
        hash_mix_next = hash_mix_reg;
        dec_key_next  = dec_key_reg;
        dec_mix_next  = dec_mix_reg;
        value_next    = value_reg;

        if (advance) begin
            unique case (item.op)
                OP_HASH: begin
                    hash_acc_next = hash_new;
                    hash_mix_next = {24'h0, item.ch} + hash_new + mix_base
                                    + (mix_base << 5) + MIX_INC;
                    value_next    = hash_new;
                end
                OP_DECRYPT: begin
                    dec_key_next = ((~key_base << 21) + KEY_ADD) | (key_base >> 11);
                    dec_mix_next = plain + dmix_sum + (dmix_sum << 5) + MIX_INC;
                    value_next   = plain;
                end
                default: begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_acc_reg <= HASH_SEED1;
            hash_mix_reg <= HASH_SEED2;
            dec_key_reg  <= '0;
            dec_mix_reg  <= HASH_SEED2;
        end else begin
            hash_acc_reg <= hash_acc_next;
            hash_mix_reg <= hash_mix_next;
            dec_key_reg  <= dec_key_next;
            dec_mix_reg  <= dec_mix_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

endmodule

@@ rtl/archive_hash_and_table_decrypt_top.sv @@
// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   s_op, s_first, s_data_in, s_hash_kind
// m_        out        m_valid / m_ready   m_value_out
//
// one request per cycle sustained while m_ready is high; a low m_ready stalls the result stage
// stage one registers the request with its crypt table rom word, stage two
// runs the hash or decrypt recurrence into the result register
// aresetn synchronous active low restores the hash and decrypt seeds
// a stalled result holds while the input stage still takes one more request
module archive_hash_and_table_decrypt_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_first,
    input  logic [31:0] s_data_in,
    input  logic [2:0]  s_hash_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value_out
);
    import ahtd_pkg::*;
    `include "archive_hash_and_table_decrypt_top_defines.svh"

    logic       s1_valid_reg, s1_valid_next;
    logic       m_valid_reg,  m_valid_next;
    logic       advance;
    logic       load;
    ahtd_item_t item;
    logic [31:0] rom_word;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next  = 1'b1;
            s1_valid_next = 1'b0;
        end
        if (load) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    ahtd_in_stage u_in_stage (
        .aclk      (aclk),
        .load      (load),
        .op        (s_op),
        .first     (s_first),
        .data_in   (s_data_in),
        .hash_kind (s_hash_kind),
        .item      (item),
        .rom_word  (rom_word)
    );

    ahtd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .rom_word  (rom_word),
        .value_out (m_value_out)
    );

    assign m_valid = m_valid_reg;

    `AHTD_ASSERT_NEXT(a_result_loaded, advance, m_valid_reg, "advanced request left no result")
    `AHTD_ASSERT_NEXT(a_request_staged, load, s1_valid_reg, "accepted request not staged")
    `AHTD_ASSERT_NEXT(a_stage_held, s1_valid_reg && !advance, s1_valid_reg, "staged request dropped")
    `AHTD_ASSERT_NOW(a_ready_low_full, s_ready || (s1_valid_reg && m_valid_reg), "ready low with room")

endmodule
